/* hdl/mmu_pkg.sv */
package mmu_pkg;

  // Access codes carried in the mode field
  localparam logic [2:0] MODE_REG_RD     = 3'd0;
  localparam logic [2:0] MODE_REG_WR     = 3'd1;
  localparam logic [2:0] MODE_TOP_RD     = 3'd2;
  localparam logic [2:0] MODE_TOP_RD_SEC = 3'd3;
  localparam logic [2:0] MODE_TOP_WR     = 3'd4;
  localparam logic [2:0] MODE_SET_LEGACY = 3'd5;

  // Read source codes
  localparam logic [2:0] SRC_REG      = 3'd0;
  localparam logic [2:0] SRC_KERNAL   = 3'd1;
  localparam logic [2:0] SRC_INT_FROM = 3'd2;
  localparam logic [2:0] SRC_EXT_FROM = 3'd3;
  localparam logic [2:0] SRC_SHARED   = 3'd4;

  // CPU switch codes
  localparam logic [1:0] SW_NONE = 2'd0;
  localparam logic [1:0] SW_MAIN = 2'd1;
  localparam logic [1:0] SW_SEC  = 2'd2;

  // Configuration port register indexes
  localparam logic [1:0] CFG_FOUR_BANKS   = 2'd0;
  localparam logic [1:0] CFG_KEY_RELEASED = 2'd1;
  localparam logic [1:0] CFG_FORCE_LEGACY = 2'd2;

  // Reset value of the force-legacy register; the pending flag loads it at reset
  localparam logic FORCE_LEGACY_RST = 1'b0;

  // Register file indexes
  localparam int unsigned NREG = 11;
  localparam logic [3:0] REG_CR   = 4'd0;
  localparam logic [3:0] REG_MCR  = 4'd5;
  localparam logic [3:0] REG_RCR  = 4'd6;
  localparam logic [3:0] REG_P0L  = 4'd7;
  localparam logic [3:0] REG_P0H  = 4'd8;
  localparam logic [3:0] REG_P1L  = 4'd9;
  localparam logic [3:0] REG_P1H  = 4'd10;
  localparam logic [7:0] REG_VER  = 8'd11;

  // Constant values
  localparam logic [7:0] VER_VALUE     = 8'h20;
  localparam logic [7:0] FORCED_CR     = 8'h3e;
  localparam logic [7:0] FORCED_MCR    = 8'hf7;
  localparam logic [7:0] FORCED_LEGACY = 8'h07;
  localparam logic [7:0] LEGACY_BASE   = 8'h80;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        exrom_line;
    logic        game_line;
  } mmu_item_t;

  // Per-access results produced by the register logic
  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] read_source;
    logic [1:0] cpu_switch;
    logic       dma_trigger;
  } mmu_acc_t;

  // Register state seen by the map decode
  typedef struct packed {
    logic [7:0] cr;
    logic [7:0] mcr;
    logic [7:0] rcr;
    logic [7:0] p0l;
    logic [7:0] p0h;
    logic [7:0] p1l;
    logic [7:0] p1h;
    logic [7:0] legacy_config;
  } mmu_state_t;

  // Status decoded from the register state
  typedef struct packed {
    logic [1:0]  bank_sel;
    logic [17:0] page_zero_addr;
    logic [17:0] page_one_addr;
    logic [7:0]  mem_config;
    logic [2:0]  second_cpu_config;
    logic        legacy_mode;
  } mmu_map_t;

endpackage

/* hdl/mmu_in_if.sv */
interface mmu_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic        exrom_line;
  logic        game_line;

  modport source (output valid, mode, address, write_data, exrom_line, game_line,
                  input ready);
  modport sink (input valid, mode, address, write_data, exrom_line, game_line,
                output ready);
endinterface

/* hdl/mmu_out_if.sv */
interface mmu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [2:0]  read_source;
  logic [1:0]  cpu_switch;
  logic        fast_serial_out;
  logic [1:0]  bank_sel;
  logic [17:0] page_zero_addr;
  logic [17:0] page_one_addr;
  logic [7:0]  mem_config;
  logic [2:0]  second_cpu_config;
  logic        legacy_mode;
  logic        dma_trigger;

  modport source (output valid, read_data, read_source, cpu_switch, fast_serial_out,
                  bank_sel, page_zero_addr, page_one_addr, mem_config,
                  second_cpu_config, legacy_mode, dma_trigger,
                  input ready);
  modport sink (input valid, read_data, read_source, cpu_switch, fast_serial_out,
                bank_sel, page_zero_addr, page_one_addr, mem_config,
                second_cpu_config, legacy_mode, dma_trigger,
                output ready);
endinterface

/* hdl/mmu_regs.sv */
module mmu_regs (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   item_valid,
  input  mmu_pkg::mmu_item_t     item,
  input  logic                   key_released,
  output mmu_pkg::mmu_acc_t      acc,
  output mmu_pkg::mmu_state_t    st_nxt,
  output logic                   fast_dir_nxt
);
  import mmu_pkg::*;

  logic [7:0] rf_r   [NREG];
  logic [7:0] rf_nxt [NREG];
  logic [7:0] p0_latch_r, p0_latch_nxt;
  logic [7:0] p1_latch_r, p1_latch_nxt;
  logic       force_pending_r, force_pending_nxt;
  logic [7:0] legacy_cfg_r, legacy_cfg_nxt;
  logic       fast_dir_r;

  logic [7:0] lo;
  logic [3:0] nib;
  logic       mirror;
  logic [7:0] mirror_val;
  logic [7:0] reg_rd_val;
  logic       ex_bit;
  logic       wr_en;
  logic [7:0] wr_idx;
  logic [7:0] wr_val;
  logic       upd;

  assign lo  = item.address[7:0];
  assign nib = item.address[3:0];
  assign mirror = (item.address[15:8] == 8'hff) && (item.address[7:3] == 5'd0) &&
                  (item.address[2:0] <= 3'd4);

  // Mirror entry value (only 0..4 are reachable when mirror is set)
  always_comb begin
    mirror_val = 8'h00;
    if (nib < 4'(NREG)) begin
      mirror_val = rf_r[nib];
    end
  end

  // Register window read
  assign ex_bit = force_pending_r ? 1'b1 : item.exrom_line;
  always_comb begin
    if (lo == 8'(REG_MCR)) begin
      reg_rd_val = {key_released, 1'b0, ~ex_bit, ~item.game_line, rf_r[REG_MCR][3:0]};
    end else if (lo == 8'(REG_P0H) || lo == 8'(REG_P1H)) begin
      reg_rd_val = rf_r[lo[3:0]] | 8'hf0;
    end else if (lo == REG_VER) begin
      reg_rd_val = VER_VALUE;
    end else if (lo < 8'(NREG)) begin
      reg_rd_val = rf_r[lo[3:0]];
    end else begin
      reg_rd_val = 8'hff;
    end
  end

  // Access decode and next state
  always_comb begin
    rf_nxt            = rf_r;
    p0_latch_nxt      = p0_latch_r;
    p1_latch_nxt      = p1_latch_r;
    force_pending_nxt = force_pending_r;
    legacy_cfg_nxt    = legacy_cfg_r;
    fast_dir_nxt      = fast_dir_r;
    acc               = '0;
    wr_en             = 1'b0;
    wr_idx            = lo;
    wr_val            = item.write_data;
    upd               = 1'b0;

    case (item.mode)
      MODE_REG_RD: begin
        acc.read_data = reg_rd_val;
      end
      MODE_REG_WR: begin
        wr_en = 1'b1;
      end
      MODE_TOP_RD: begin
        if (mirror) begin
          acc.read_data = mirror_val;
        end else begin
          case (rf_r[REG_CR][5:4])
            2'd0:    acc.read_source = SRC_KERNAL;
            2'd1:    acc.read_source = SRC_INT_FROM;
            2'd2:    acc.read_source = SRC_EXT_FROM;
            default: acc.read_source = SRC_SHARED;
          endcase
        end
      end
      MODE_TOP_RD_SEC: begin
        if (mirror) begin
          acc.read_data = mirror_val;
        end else begin
          acc.read_source = SRC_SHARED;
        end
      end
      MODE_TOP_WR: begin
        wr_idx = 8'(REG_CR);
        if (item.address == 16'hff00) begin
          wr_en           = 1'b1;
          acc.dma_trigger = 1'b1;
        end else if (mirror) begin
          wr_en  = 1'b1;
          wr_val = mirror_val;
        end
      end
      MODE_SET_LEGACY: begin
        if (item_valid) begin
          legacy_cfg_nxt = item.write_data;
          upd            = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Register write; indexes past the file are dropped
    if (wr_en && wr_idx < 8'(NREG)) begin
      if (wr_idx[3:0] == REG_MCR && (wr_val[0] ^ rf_r[REG_MCR][0])) begin
        acc.cpu_switch = wr_val[0] ? SW_MAIN : SW_SEC;
      end
      if (item_valid) begin
        upd = 1'b1;
        case (wr_idx[3:0])
          REG_MCR: begin
            fast_dir_nxt     = wr_val[3];
            rf_nxt[REG_MCR]  = wr_val;
          end
          REG_P0L: begin
            rf_nxt[REG_P0L] = wr_val;
            rf_nxt[REG_P0H] = p0_latch_r;
          end
          REG_P0H: p0_latch_nxt = wr_val;
          REG_P1L: begin
            rf_nxt[REG_P1L] = wr_val;
            rf_nxt[REG_P1H] = p1_latch_r;
          end
          REG_P1H: p1_latch_nxt = wr_val;
          default: rf_nxt[wr_idx[3:0]] = wr_val;
        endcase
      end
    end

    // Forced legacy mode takes effect once legacy mode is selected
    if (upd && rf_nxt[REG_MCR][6]) begin
      if (force_pending_r) begin
        legacy_cfg_nxt  = FORCED_LEGACY;
        rf_nxt[REG_CR]  = FORCED_CR;
        rf_nxt[REG_MCR] = FORCED_MCR;
        rf_nxt[REG_P0L] = 8'h00;
        rf_nxt[REG_P0H] = 8'h00;
        rf_nxt[REG_P1L] = 8'h01;
        rf_nxt[REG_P1H] = 8'h00;
      end
      force_pending_nxt = 1'b0;
    end
  end

  assign st_nxt.cr            = rf_nxt[REG_CR];
  assign st_nxt.mcr           = rf_nxt[REG_MCR];
  assign st_nxt.rcr           = rf_nxt[REG_RCR];
  assign st_nxt.p0l           = rf_nxt[REG_P0L];
  assign st_nxt.p0h           = rf_nxt[REG_P0H];
  assign st_nxt.p1l           = rf_nxt[REG_P1L];
  assign st_nxt.p1h           = rf_nxt[REG_P1H];
  assign st_nxt.legacy_config = legacy_cfg_nxt;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREG; i++) begin
        rf_r[i] <= (i == int'(REG_P1L)) ? 8'h01 : 8'h00;
      end
      p0_latch_r      <= 8'h00;
      p1_latch_r      <= 8'h00;
      force_pending_r <= FORCE_LEGACY_RST;
      legacy_cfg_r    <= 8'h00;
      fast_dir_r      <= 1'b0;
    end else if (item_valid) begin
      rf_r            <= rf_nxt;
      p0_latch_r      <= p0_latch_nxt;
      p1_latch_r      <= p1_latch_nxt;
      force_pending_r <= force_pending_nxt;
      legacy_cfg_r    <= legacy_cfg_nxt;
      fast_dir_r      <= fast_dir_nxt;
    end
  end

endmodule

/* hdl/mmu_map.sv */
module mmu_map (
  input  mmu_pkg::mmu_state_t st,
  input  logic                four_banks,
  output mmu_pkg::mmu_map_t   map
);
  import mmu_pkg::*;

  // Relocated page address; shared windows pin the bank to zero
  function automatic logic [17:0] page_addr(input logic [7:0] page, input logic [7:0] high,
                                            input logic [7:0] rcr, input logic four);
    logic [1:0] bank;
    logic [7:0] lim;
    logic       shared;
    bank = four ? high[1:0] : {1'b0, high[0]};
    case (rcr[1:0])
      2'd0:    lim = 8'd4;
      2'd1:    lim = 8'd16;
      2'd2:    lim = 8'd32;
      default: lim = 8'd64;
    endcase
    shared = (rcr[2] && page < lim) || (rcr[3] && page >= 8'(9'd256 - 9'(lim)));
    if (shared) begin
      bank = 2'd0;
    end
    return {bank, page, 8'h00};
  endfunction

  always_comb begin
    map.bank_sel       = four_banks ? st.cr[7:6] : {1'b0, st.cr[6]};
    map.page_zero_addr = page_addr(st.p0l, st.p0h, st.rcr, four_banks);
    map.page_one_addr  = page_addr(st.p1l, st.p1h, st.rcr, four_banks);
    if (st.mcr[6]) begin
      map.mem_config = LEGACY_BASE + st.legacy_config;
    end else begin
      map.mem_config = {1'b0, ~st.cr[0], st.cr[6], st.cr[5:4], st.cr[3:2], ~st.cr[1]};
    end
    map.second_cpu_config = {st.cr[7], st.cr[6], ~st.cr[0]};
    map.legacy_mode       = st.mcr[6];
  end

endmodule

/* hdl/banked_memory_mmu_registers_unit.sv */
// Banked memory management unit register block. Every bus access (register
// read or write, read or write of the FF00-FF04 mirror, legacy configuration
// update) yields one result transaction carrying the read byte or top-page
// source, any CPU switch, and the memory map status after the access. An
// access passes through the input register, then through the register
// update and map decode into the result register. A new access is taken
// every cycle while results are collected; a stalled result holds one more
// access in the input register before in_ch.ready drops. Configuration
// writes are registered and should be made while idle.
module banked_memory_mmu_registers_unit (
  input  logic       clk,
  input  logic       rst_n,
  mmu_in_if.sink     in_ch,
  mmu_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [0:0] cfg_wdata
);
  import mmu_pkg::*;

  logic       four_banks_r;
  logic       key_released_r;

  logic       in_valid_r;
  mmu_item_t  in_item_r;
  logic       out_valid_r;
  logic       advance;
  logic       fire;

  mmu_acc_t   acc;
  mmu_state_t st_nxt;
  logic       fast_dir_nxt;
  mmu_map_t   map;

  mmu_acc_t   acc_r;
  mmu_map_t   map_r;
  logic       fast_dir_r;

  // Configuration registers; writes to the force-legacy index are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_banks_r   <= 1'b0;
      key_released_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_FOUR_BANKS:   four_banks_r   <= cfg_wdata[0];
        CFG_KEY_RELEASED: key_released_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Handshake
  assign advance     = !out_valid_r || out_ch.ready;
  assign fire        = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.mode       <= in_ch.mode;
      in_item_r.address    <= in_ch.address;
      in_item_r.write_data <= in_ch.write_data;
      in_item_r.exrom_line <= in_ch.exrom_line;
      in_item_r.game_line  <= in_ch.game_line;
    end
  end

  mmu_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (fire),
    .item         (in_item_r),
    .key_released (key_released_r),
    .acc          (acc),
    .st_nxt       (st_nxt),
    .fast_dir_nxt (fast_dir_nxt)
  );

  mmu_map u_map (
    .st         (st_nxt),
    .four_banks (four_banks_r),
    .map        (map)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      acc_r      <= acc;
      map_r      <= map;
      fast_dir_r <= fast_dir_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.read_data         = acc_r.read_data;
  assign out_ch.read_source       = acc_r.read_source;
  assign out_ch.cpu_switch        = acc_r.cpu_switch;
  assign out_ch.dma_trigger       = acc_r.dma_trigger;
  assign out_ch.fast_serial_out   = fast_dir_r;
  assign out_ch.bank_sel          = map_r.bank_sel;
  assign out_ch.page_zero_addr    = map_r.page_zero_addr;
  assign out_ch.page_one_addr     = map_r.page_one_addr;
  assign out_ch.mem_config        = map_r.mem_config;
  assign out_ch.second_cpu_config = map_r.second_cpu_config;
  assign out_ch.legacy_mode       = map_r.legacy_mode;

  // A DMA trigger write never reports read data or a source
  a_dma_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && acc_r.dma_trigger |-> acc_r.read_data == 8'h00 &&
    acc_r.read_source == SRC_REG)
    else $error("dma trigger with read data");

  // Outside legacy mode the map word and second CPU word agree on the CPU bit
  a_cfg_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !map_r.legacy_mode |-> map_r.mem_config[7] == 1'b0 &&
    map_r.mem_config[6] == map_r.second_cpu_config[0])
    else $error("map words disagree");

  // An access moved out of the input register always shows up as a result
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("access lost");

endmodule
